FILE: rtl/core/rbst_pkg.sv
// Shared constants and types for the ray / box slab test.
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int N_AXES      = 3;
  localparam int N_FIELDS    = 4 * N_AXES;

  // corner - origin, exact
  localparam int DIFF_W = COORD_WIDTH + 1;
  // magnitude of the scaled dividend
  localparam int NUM_W  = COORD_WIDTH + FRAC_BITS + 1;
  // magnitude of the divisor
  localparam int DEN_W  = COORD_WIDTH;
  // signed quotient
  localparam int QUO_W  = NUM_W + 1;
  // divider depth in stages: magnitude stage, one stage per quotient bit, sign stage
  localparam int DIV_DEPTH = NUM_W + 2;

  localparam int IN_W  = N_FIELDS * COORD_WIDTH;
  localparam int OUT_W = 8;

  typedef struct packed {
    logic                    valid;
    logic                    zero;   // direction component is zero
    logic                    pass;   // origin inside slab (zero direction only)
    logic signed [QUO_W-1:0] lo;
    logic signed [QUO_W-1:0] hi;
  } lane_res_t;

endpackage

FILE: rtl/core/rbst_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module rbst_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [rbst_pkg::DIFF_W-1:0]   num,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] den,
  output logic                                 out_valid,
  output logic signed [rbst_pkg::QUO_W-1:0]    quo
);

  localparam int NW = rbst_pkg::NUM_W;
  localparam int DW = rbst_pkg::DEN_W;

  logic [rbst_pkg::DIFF_W-1:0] num_mag;
  logic [DW-1:0]               den_mag;

  assign num_mag = num[rbst_pkg::DIFF_W-1] ? rbst_pkg::DIFF_W'(-num)
                                           : rbst_pkg::DIFF_W'(num);
  assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

  // entry stage: magnitudes and result sign
  logic          e_valid;
  logic [NW-1:0] e_num;
  logic [DW-1:0] e_den;
  logic          e_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
    end
    if (en) begin
      e_num <= {num_mag, {rbst_pkg::FRAC_BITS{1'b0}}};
      e_den <= den_mag;
      e_neg <= num[rbst_pkg::DIFF_W-1] ^ den[DW-1];
    end
  end

  logic          s_valid [NW];
  logic [NW-1:0] s_num   [NW];
  logic [DW-1:0] s_rem   [NW];
  logic [NW-1:0] s_q     [NW];
  logic [DW-1:0] s_den   [NW];
  logic          s_neg   [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          p_valid;
    logic [NW-1:0] p_num;
    logic [DW-1:0] p_rem;
    logic [NW-1:0] p_q;
    logic [DW-1:0] p_den;
    logic          p_neg;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    if (s == 0) begin : g_first
      assign p_valid = e_valid;
      assign p_num   = e_num;
      assign p_rem   = '0;
      assign p_q     = '0;
      assign p_den   = e_den;
      assign p_neg   = e_neg;
    end else begin : g_next
      assign p_valid = s_valid[s-1];
      assign p_num   = s_num[s-1];
      assign p_rem   = s_rem[s-1];
      assign p_q     = s_q[s-1];
      assign p_den   = s_den[s-1];
      assign p_neg   = s_neg[s-1];
    end

    assign trial = {p_rem, p_num[NW-1]};
    assign ge    = trial >= {1'b0, p_den};
    assign diff  = trial - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[s] <= 1'b0;
      end else if (en) begin
        s_valid[s] <= p_valid;
      end
      if (en) begin
        s_num[s] <= {p_num[NW-2:0], 1'b0};
        s_rem[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        s_q[s]   <= {p_q[NW-2:0], ge};
        s_den[s] <= p_den;
        s_neg[s] <= p_neg;
      end
    end
  end

  // sign stage
  logic signed [rbst_pkg::QUO_W-1:0] q_pos;
  assign q_pos = $signed({1'b0, s_q[NW-1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid[NW-1];
    end
    if (en) begin
      quo <= s_neg[NW-1] ? -q_pos : q_pos;
    end
  end

`ifndef SYNTHESIS
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(quo) && $stable(out_valid))
    else $error("divider output moved while stalled");
`endif

endmodule

FILE: rtl/core/rbst_lane.sv
// One axis: slab differences, two dividers, zero-direction check, ordering.
module rbst_lane (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] origin,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] dir,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] box_min,
  input  logic signed [rbst_pkg::COORD_WIDTH-1:0] box_max,
  output rbst_pkg::lane_res_t                     res
);

  localparam int CW  = rbst_pkg::COORD_WIDTH;
  localparam int DL  = rbst_pkg::DIV_DEPTH;

  logic                                r_valid;
  logic signed [rbst_pkg::DIFF_W-1:0]  r_da;
  logic signed [rbst_pkg::DIFF_W-1:0]  r_db;
  logic signed [CW-1:0]                r_dir;
  logic                                r_zero;
  logic                                r_pass;

  logic in_lo_ok;
  logic in_hi_ok;
  // slab between the two corners in either order, inclusive
  assign in_lo_ok = (origin >= box_min) || (origin >= box_max);
  assign in_hi_ok = (origin <= box_min) || (origin <= box_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= in_valid;
    end
    if (en) begin
      r_da   <= rbst_pkg::DIFF_W'(box_min) - rbst_pkg::DIFF_W'(origin);
      r_db   <= rbst_pkg::DIFF_W'(box_max) - rbst_pkg::DIFF_W'(origin);
      r_dir  <= dir;
      r_zero <= (dir == '0);
      r_pass <= in_lo_ok && in_hi_ok;
    end
  end

  logic                              va;
  logic                              vb;
  logic signed [rbst_pkg::QUO_W-1:0] qa;
  logic signed [rbst_pkg::QUO_W-1:0] qb;

  rbst_div u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid),
    .num(r_da), .den(r_dir), .out_valid(va), .quo(qa)
  );

  rbst_div u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid),
    .num(r_db), .den(r_dir), .out_valid(vb), .quo(qb)
  );

  // flags ride alongside the dividers
  logic d_zero [DL];
  logic d_pass [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      d_zero[0] <= r_zero;
      d_pass[0] <= r_pass;
      for (int i = 1; i < DL; i++) begin
        d_zero[i] <= d_zero[i-1];
        d_pass[i] <= d_pass[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= va && vb;
    end
    if (en) begin
      res.zero <= d_zero[DL-1];
      res.pass <= d_pass[DL-1];
      res.lo   <= (qa > qb) ? qb : qa;
      res.hi   <= (qa > qb) ? qa : qb;
    end
  end

`ifndef SYNTHESIS
  a_lane_order: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.lo <= res.hi)
    else $error("slab interval not ordered");
  a_lane_sync: assert property (@(posedge clk) disable iff (rst)
    va == vb)
    else $error("divider pair out of step");
`endif

endmodule

FILE: rtl/core/rbst_merge.sv
// Intersects the per-axis intervals and registers the hit word.
module rbst_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rbst_pkg::lane_res_t lanes [rbst_pkg::N_AXES],
  output logic                out_valid,
  output logic                hit
);

  localparam int QW = rbst_pkg::QUO_W;

  logic signed [QW-1:0] lo_c;
  logic signed [QW-1:0] hi_c;
  logic                 zok_c;

  always_comb begin
    lo_c  = {1'b1, {(QW-1){1'b0}}};
    hi_c  = {1'b0, {(QW-1){1'b1}}};
    zok_c = 1'b1;
    for (int i = 0; i < rbst_pkg::N_AXES; i++) begin
      if (lanes[i].zero) begin
        zok_c = zok_c && lanes[i].pass;
      end else begin
        if (lanes[i].lo > lo_c) lo_c = lanes[i].lo;
        if (lanes[i].hi < hi_c) hi_c = lanes[i].hi;
      end
    end
  end

  logic                 m_valid;
  logic signed [QW-1:0] m_lo;
  logic signed [QW-1:0] m_hi;
  logic                 m_zok;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= lanes[0].valid;
      out_valid <= m_valid;
    end
    if (en) begin
      m_lo <= lo_c;
      m_hi <= hi_c;
      m_zok <= zok_c;
      hit  <= m_zok && (m_lo <= m_hi);
    end
  end

`ifndef SYNTHESIS
  a_merge_sync: assert property (@(posedge clk) disable iff (rst)
    lanes[0].valid == lanes[1].valid && lanes[1].valid == lanes[2].valid)
    else $error("lanes out of step");
  a_merge_adv: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid == $past(m_valid))
    else $error("output stage did not advance");
`endif

endmodule

FILE: rtl/core/ray_box_slab_test_top.sv
// Top level of the ray / axis-aligned box slab test.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  s_      | in  | s_tvalid / s_tready   | s_tdata: ray + box, 12 x 32 bits
//  m_      | out | m_tvalid / m_tready   | m_tdata: hit flag, 8 bits
//
// One word accepted per cycle while the output stage is free or being taken.
// Pipeline in order: input register, difference register,
// 51-stage divider (one quotient bit per stage), ordering, two merge stages.
// Three axis lanes run side by side, each with two dividers.
// Synchronous active-high reset clears only the valid bits.
// A stall on m_ holds the whole pipe; s_tready drops with it.
module ray_box_slab_test_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [rbst_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // hit, then zero fill
  output logic [rbst_pkg::OUT_W-1:0] m_tdata
);

  localparam int CW = rbst_pkg::COORD_WIDTH;
  localparam int NA = rbst_pkg::N_AXES;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input register
  logic                     in_valid;
  logic [rbst_pkg::IN_W-1:0] in_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_tvalid;
    end
    if (en) begin
      in_word <= s_tdata;
    end
  end

  rbst_pkg::lane_res_t lanes [NA];

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbst_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_valid(in_valid),
      .origin  ($signed(in_word[a*CW +: CW])),
      .dir     ($signed(in_word[(NA+a)*CW +: CW])),
      .box_min ($signed(in_word[(2*NA+a)*CW +: CW])),
      .box_max ($signed(in_word[(3*NA+a)*CW +: CW])),
      .res     (lanes[a])
    );
  end

  logic hit;

  rbst_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .lanes    (lanes),
    .out_valid(m_tvalid),
    .hit      (hit)
  );

  assign m_tdata = {{(rbst_pkg::OUT_W-1){1'b0}}, hit};

`ifndef SYNTHESIS
  a_top_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped under stall");
`endif

endmodule
